### rtl/point_segment_distance_3d_unit_defines.svh
// Assertion macros for the point to segment distance checker.
`ifndef POINT_SEGMENT_DISTANCE_3D_UNIT_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_3D_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSD3_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psd3 checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PSD3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psd3 checker: next-cycle property failed");

`endif

### rtl/psd3_pkg.sv
// Shared widths, region codes and stage bundles for the distance unit.
`default_nettype none

package psd3_pkg;

  localparam int CRD_W      = 16;               // input coordinate
  localparam int DIF_W      = CRD_W + 1;        // coordinate difference
  localparam int PRD_W      = 2 * DIF_W;        // product of two differences
  localparam int DOT_W      = PRD_W + 2;        // signed dot product
  localparam int LEN_W      = PRD_W;            // squared length, unsigned
  localparam int CRS_W      = PRD_W + 1;        // cross product component
  localparam int MAG_W      = PRD_W;            // cross component magnitude
  localparam int SQ_W       = 2 * MAG_W;        // squared cross norm
  localparam int FRAC_SHIFT = 16;               // 8 result fraction bits, squared
  localparam int NUM_W      = SQ_W + FRAC_SHIFT;
  localparam int QUO_W      = LEN_W + FRAC_SHIFT;
  localparam int RAD_W      = QUO_W;            // radicand of the square root
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQ_REM_W   = ROOT_W + 2;
  localparam int AXES       = 3;

  typedef enum logic [1:0] {
    REGION_START    = 2'd0,
    REGION_END      = 2'd1,
    REGION_INTERIOR = 2'd2
  } psd3_region_t;

  typedef struct packed {
    psd3_region_t           region;
    logic [RAD_W-1:0]       alt;     // endpoint radicand for start/end regions
  } psd3_side_t;

  typedef struct packed {
    logic                   valid;
    logic [NUM_W-1:0]       num;
    logic [LEN_W-1:0]       den;
    psd3_side_t             side;
  } psd3_div_in_t;

  typedef struct packed {
    logic                   valid;
    logic [QUO_W-1:0]       quo;
    psd3_side_t             side;
  } psd3_div_out_t;

  typedef struct packed {
    logic                   valid;
    logic [RAD_W-1:0]       rad;
    psd3_region_t           region;
  } psd3_sqrt_in_t;

  typedef struct packed {
    logic                   valid;
    logic [ROOT_W-1:0]      root;
    psd3_region_t           region;
  } psd3_sqrt_out_t;

endpackage

`default_nettype wire

### rtl/psd3_if.sv
// Valid/ready channel interfaces for query items and distance items.
`default_nettype none

interface psd3_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] start_z;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic signed [15:0] end_z;

  modport source (output valid, point_x, point_y, point_z, start_x, start_y, start_z,
                  end_x, end_y, end_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, start_x, start_y, start_z,
                  end_x, end_y, end_z, output ready);
endinterface

interface psd3_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] distance;
  logic [1:0]  region;

  modport source (output valid, distance, region, input ready);
  modport sink   (input valid, distance, region, output ready);
endinterface

`default_nettype wire

### rtl/point_segment_distance_3d_unit.sv
// Top level: point to 3D segment distance, fully pipelined.
// One query item enters per clock unless out_ch is stalled; each item runs:
// five arithmetic stages (differences, 17x17 products, dot/cross sums, region
// pick with cross squares, cross-norm sum), a 50-stage divider for the interior
// squared distance scaled by 65536, and a 25-stage floor square root. Every item
// runs the full depth whatever its region, so results leave in input order. The
// whole pipe advances when the output register is empty or being taken; while
// out_ch is stalled with a result held, in_ch.ready is low. distance carries 8
// fraction bits; region is 0 for start, 1 for end, 2 for interior (a projection
// landing exactly on the end counts as interior, a zero-length segment as start).
`default_nettype none

module point_segment_distance_3d_unit (
  input  logic        clk,
  input  logic        rst_n,
  psd3_in_if.sink     in_ch,
  psd3_out_if.source  out_ch
);
  import psd3_pkg::*;

  logic                    adv;
  psd3_div_in_t            div_in;
  psd3_div_out_t           div_out;
  psd3_sqrt_in_t           sq_in;
  psd3_sqrt_out_t          sq_out;

  // pipe moves when the output slot is free or drained this cycle
  assign adv         = !sq_out.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage A: differences d = E-S, v = P-S, w = P-E
  logic signed [CRD_W-1:0] pt [AXES];
  logic signed [CRD_W-1:0] st [AXES];
  logic signed [CRD_W-1:0] en [AXES];
  logic signed [DIF_W-1:0] a_d_nxt [AXES];
  logic signed [DIF_W-1:0] a_v_nxt [AXES];
  logic signed [DIF_W-1:0] a_w_nxt [AXES];
  logic                    a_vld_r;
  logic signed [DIF_W-1:0] a_d_r [AXES];
  logic signed [DIF_W-1:0] a_v_r [AXES];
  logic signed [DIF_W-1:0] a_w_r [AXES];

  assign pt[0] = in_ch.point_x;
  assign pt[1] = in_ch.point_y;
  assign pt[2] = in_ch.point_z;
  assign st[0] = in_ch.start_x;
  assign st[1] = in_ch.start_y;
  assign st[2] = in_ch.start_z;
  assign en[0] = in_ch.end_x;
  assign en[1] = in_ch.end_y;
  assign en[2] = in_ch.end_z;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      a_d_nxt[i] = DIF_W'(en[i]) - DIF_W'(st[i]);
      a_v_nxt[i] = DIF_W'(pt[i]) - DIF_W'(st[i]);
      a_w_nxt[i] = DIF_W'(pt[i]) - DIF_W'(en[i]);
    end
  end

  // stage B: products for the dot sums and the cross product
  logic                    b_vld_r;
  logic signed [PRD_W-1:0] b_vd_r [AXES];
  logic signed [PRD_W-1:0] b_dd_r [AXES];
  logic signed [PRD_W-1:0] b_vv_r [AXES];
  logic signed [PRD_W-1:0] b_ww_r [AXES];
  logic signed [PRD_W-1:0] b_xa_r [AXES];
  logic signed [PRD_W-1:0] b_xb_r [AXES];

  // stage C: dot products and cross product
  logic signed [DOT_W-1:0] c_e_nxt;
  logic signed [DOT_W-1:0] c_len_sum;
  logic signed [DOT_W-1:0] c_vv_sum;
  logic signed [DOT_W-1:0] c_ww_sum;
  logic signed [CRS_W-1:0] c_crs_nxt [AXES];
  logic                    c_vld_r;
  logic signed [DOT_W-1:0] c_e_r;
  logic [LEN_W-1:0]        c_len_r;
  logic [LEN_W-1:0]        c_vv_r;
  logic [LEN_W-1:0]        c_ww_r;
  logic signed [CRS_W-1:0] c_crs_r [AXES];

  always_comb begin
    c_e_nxt   = DOT_W'(b_vd_r[0]) + DOT_W'(b_vd_r[1]) + DOT_W'(b_vd_r[2]);
    c_len_sum = DOT_W'(b_dd_r[0]) + DOT_W'(b_dd_r[1]) + DOT_W'(b_dd_r[2]);
    c_vv_sum  = DOT_W'(b_vv_r[0]) + DOT_W'(b_vv_r[1]) + DOT_W'(b_vv_r[2]);
    c_ww_sum  = DOT_W'(b_ww_r[0]) + DOT_W'(b_ww_r[1]) + DOT_W'(b_ww_r[2]);
    for (int i = 0; i < AXES; i++) begin
      c_crs_nxt[i] = CRS_W'(b_xa_r[i]) - CRS_W'(b_xb_r[i]);
    end
  end

  // stage D: region pick, endpoint radicand, cross squares
  psd3_region_t            d_region_nxt;
  logic [LEN_W-1:0]        d_sel;
  logic signed [CRS_W-1:0] d_neg [AXES];
  logic [MAG_W-1:0]        d_mag [AXES];
  logic                    d_vld_r;
  psd3_region_t            d_region_r;
  logic [LEN_W-1:0]        d_len_r;
  logic [RAD_W-1:0]        d_alt_r;
  logic [SQ_W-1:0]         d_sq_r [AXES];

  always_comb begin
    if (c_e_r[DOT_W-1] || (c_e_r == '0)) begin
      d_region_nxt = REGION_START;
    end else if (c_e_r > $signed({2'b00, c_len_r})) begin
      d_region_nxt = REGION_END;
    end else begin
      d_region_nxt = REGION_INTERIOR;
    end
    d_sel = (d_region_nxt == REGION_END) ? c_ww_r : c_vv_r;
    for (int i = 0; i < AXES; i++) begin
      d_neg[i] = -c_crs_r[i];
      d_mag[i] = c_crs_r[i][CRS_W-1] ? d_neg[i][MAG_W-1:0] : c_crs_r[i][MAG_W-1:0];
    end
  end

  // stage E: squared cross norm, scaled numerator
  logic [SQ_W-1:0]         e_c2_nxt;
  logic                    e_vld_r;
  logic [NUM_W-1:0]        e_num_r;
  logic [LEN_W-1:0]        e_den_r;
  psd3_side_t              e_side_r;

  assign e_c2_nxt = d_sq_r[0] + d_sq_r[1] + d_sq_r[2];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_ch.valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
    end
  end

  // front stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        a_d_r[i]  <= a_d_nxt[i];
        a_v_r[i]  <= a_v_nxt[i];
        a_w_r[i]  <= a_w_nxt[i];
        b_vd_r[i] <= a_v_r[i] * a_d_r[i];
        b_dd_r[i] <= a_d_r[i] * a_d_r[i];
        b_vv_r[i] <= a_v_r[i] * a_v_r[i];
        b_ww_r[i] <= a_w_r[i] * a_w_r[i];
        c_crs_r[i] <= c_crs_nxt[i];
        d_sq_r[i]  <= d_mag[i] * d_mag[i];
      end
      b_xa_r[0] <= a_v_r[1] * a_d_r[2];
      b_xb_r[0] <= a_v_r[2] * a_d_r[1];
      b_xa_r[1] <= a_v_r[2] * a_d_r[0];
      b_xb_r[1] <= a_v_r[0] * a_d_r[2];
      b_xa_r[2] <= a_v_r[0] * a_d_r[1];
      b_xb_r[2] <= a_v_r[1] * a_d_r[0];
      c_e_r      <= c_e_nxt;
      c_len_r    <= c_len_sum[LEN_W-1:0];
      c_vv_r     <= c_vv_sum[LEN_W-1:0];
      c_ww_r     <= c_ww_sum[LEN_W-1:0];
      d_region_r <= d_region_nxt;
      d_len_r    <= c_len_r;
      d_alt_r    <= {d_sel, {FRAC_SHIFT{1'b0}}};
      e_num_r    <= {e_c2_nxt, {FRAC_SHIFT{1'b0}}};
      e_den_r    <= d_len_r;
      e_side_r.region <= d_region_r;
      e_side_r.alt    <= d_alt_r;
    end
  end

  assign div_in.valid = e_vld_r;
  assign div_in.num   = e_num_r;
  assign div_in.den   = e_den_r;
  assign div_in.side  = e_side_r;

  psd3_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .div_in  (div_in),
    .div_out (div_out)
  );

  // interior uses the quotient, endpoints their own squared distance
  assign sq_in.valid  = div_out.valid;
  assign sq_in.region = div_out.side.region;
  assign sq_in.rad    = (div_out.side.region == REGION_INTERIOR) ? div_out.quo
                                                                 : div_out.side.alt;

  psd3_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .sq_in  (sq_in),
    .sq_out (sq_out)
  );

  assign out_ch.valid    = sq_out.valid;
  assign out_ch.distance = sq_out.root;
  assign out_ch.region   = sq_out.region;

endmodule

`default_nettype wire

### rtl/psd3_div.sv
// Fully pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module psd3_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  psd3_pkg::psd3_div_in_t  div_in,
  output psd3_pkg::psd3_div_out_t div_out
);
  import psd3_pkg::*;

  logic                 vld_r  [QUO_W];
  logic [LEN_W-1:0]     rem_r  [QUO_W];
  logic [LEN_W-1:0]     den_r  [QUO_W];
  logic [QUO_W-1:0]     lo_r   [QUO_W];
  logic [QUO_W-1:0]     q_r    [QUO_W];
  psd3_side_t           side_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             vld_in;
    logic [LEN_W-1:0] rem_in;
    logic [LEN_W-1:0] den_in;
    logic [QUO_W-1:0] lo_in;
    logic [QUO_W-1:0] q_in;
    psd3_side_t       side_in;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             qbit;
    logic [LEN_W-1:0] rem_nxt;

    if (k == 0) begin : g_first
      // top numerator bits seed the remainder
      assign vld_in  = div_in.valid;
      assign rem_in  = div_in.num[NUM_W-1:QUO_W];
      assign den_in  = div_in.den;
      assign lo_in   = div_in.num[QUO_W-1:0];
      assign q_in    = '0;
      assign side_in = div_in.side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign lo_in   = lo_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    // shift in next numerator bit, subtract divisor when it fits
    always_comb begin
      trial   = {rem_in, lo_in[QUO_W-1]};
      diff    = trial - {1'b0, den_in};
      qbit    = (trial >= {1'b0, den_in});
      rem_nxt = qbit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        lo_r[k]   <= {lo_in[QUO_W-2:0], 1'b0};
        q_r[k]    <= {q_in[QUO_W-2:0], qbit};
        side_r[k] <= side_in;
      end
    end
  end

  assign div_out.valid = vld_r[QUO_W-1];
  assign div_out.quo   = q_r[QUO_W-1];
  assign div_out.side  = side_r[QUO_W-1];

endmodule

`default_nettype wire

### rtl/psd3_sqrt.sv
// Fully pipelined digit-by-digit floor square root, one root bit per stage.
`default_nettype none

module psd3_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  psd3_pkg::psd3_sqrt_in_t  sq_in,
  output psd3_pkg::psd3_sqrt_out_t sq_out
);
  import psd3_pkg::*;

  logic                  vld_r  [ROOT_W];
  logic [SQ_REM_W-1:0]   rem_r  [ROOT_W];
  logic [RAD_W-1:0]      rad_r  [ROOT_W];
  logic [ROOT_W-1:0]     root_r [ROOT_W];
  psd3_region_t          reg_r  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic                  vld_in;
    logic [SQ_REM_W-1:0]   rem_in;
    logic [RAD_W-1:0]      rad_in;
    logic [ROOT_W-1:0]     root_in;
    psd3_region_t          reg_in;
    logic [SQ_REM_W+1:0]   t;
    logic [SQ_REM_W+1:0]   trial;
    logic [SQ_REM_W+1:0]   diff;
    logic                  ge;
    logic [SQ_REM_W-1:0]   rem_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = sq_in.valid;
      assign rem_in  = '0;
      assign rad_in  = sq_in.rad;
      assign root_in = '0;
      assign reg_in  = sq_in.region;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign root_in = root_r[k-1];
      assign reg_in  = reg_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      t       = {rem_in, rad_in[RAD_W-1 -: 2]};
      trial   = {2'b00, root_in, 2'b01};
      diff    = t - trial;
      ge      = (t >= trial);
      rem_nxt = ge ? diff[SQ_REM_W-1:0] : t[SQ_REM_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_nxt;
        rad_r[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        root_r[k] <= {root_in[ROOT_W-2:0], ge};
        reg_r[k]  <= reg_in;
      end
    end
  end

  assign sq_out.valid  = vld_r[ROOT_W-1];
  assign sq_out.root   = root_r[ROOT_W-1];
  assign sq_out.region = reg_r[ROOT_W-1];

endmodule

`default_nettype wire

### rtl/psd3_checker.sv
// Port-level checker for the distance unit, bound to the top level.
`default_nettype none
`include "point_segment_distance_3d_unit_defines.svh"

module psd3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [24:0] out_distance,
  input logic [1:0]  out_region
);
  import psd3_pkg::*;

  // only the three defined region codes come out
  `PSD3_ASSERT_NOW(a_region_code, out_valid, out_region <= REGION_INTERIOR)

  // an empty output slot never blocks the input
  `PSD3_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // a taken result frees the pipe in the same cycle
  `PSD3_ASSERT_NOW(a_ready_on_drain, out_valid && out_ready, in_ready)

  // a held result stays put
  `PSD3_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(out_distance) && $stable(out_region))

  // nothing enters while the output is held
  `PSD3_ASSERT_NOW(a_no_entry_stalled, out_valid && !out_ready, !(in_valid && in_ready))

endmodule

bind point_segment_distance_3d_unit psd3_checker u_psd3_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_distance (out_ch.distance),
  .out_region   (out_ch.region)
);

`default_nettype wire

### bench/psd3_tb_pkg.sv
// Test-side types for the point to segment distance bench.
`timescale 1ns / 100ps

package psd3_tb_pkg;
  import psd3_pkg::*;

  typedef struct packed {
    logic signed [15:0] px, py, pz;
    logic signed [15:0] sx, sy, sz;
    logic signed [15:0] ex, ey, ez;
  } query_t;

  typedef struct packed {
    logic [24:0]  distance;
    psd3_region_t region;
  } dist_t;
endpackage

### bench/point_segment_distance_3d_unit_tb.sv
// Testbench for the point to segment distance unit: random and corner queries.
`timescale 1ns / 100ps

module point_segment_distance_3d_unit_tb;
  import psd3_pkg::*;
  import psd3_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_cnt = 0;
  bit   feed_done = 1'b0;
  bit   no_idle = 1'b0;
  bit   in_taken = 1'b0;

  query_t query_q[$];
  dist_t  dist_q[$];

  psd3_in_if  in_ch();
  psd3_out_if out_ch();

  point_segment_distance_3d_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // append one pending query
  function automatic void add_query(query_t q);
    query_q.insert(query_q.size(), q);
  endfunction

  // floor square root of a 64-bit value
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // expected distance item for one query
  function automatic dist_t seg_distance(query_t q);
    longint d[3], v[3], w[3];
    longint proj, len2, vv, ww, cx, cy, cz;
    logic [127:0] c2;
    longint unsigned quo;
    dist_t r;
    d[0] = q.ex - q.sx; d[1] = q.ey - q.sy; d[2] = q.ez - q.sz;
    v[0] = q.px - q.sx; v[1] = q.py - q.sy; v[2] = q.pz - q.sz;
    w[0] = q.px - q.ex; w[1] = q.py - q.ey; w[2] = q.pz - q.ez;
    proj = 0; len2 = 0; vv = 0; ww = 0;
    for (int i = 0; i < 3; i++) begin
      proj += v[i] * d[i];
      len2 += d[i] * d[i];
      vv   += v[i] * v[i];
      ww   += w[i] * w[i];
    end
    if (proj <= 0) begin
      r.region = REGION_START;
      r.distance = 25'(floor_root(64'(vv) << 16));
    end else if (proj > len2) begin
      r.region = REGION_END;
      r.distance = 25'(floor_root(64'(ww) << 16));
    end else begin
      cx = v[1] * d[2] - v[2] * d[1];
      cy = v[2] * d[0] - v[0] * d[2];
      cz = v[0] * d[1] - v[1] * d[0];
      c2 = 128'($signed(128'(cx)) * $signed(128'(cx)))
         + 128'($signed(128'(cy)) * $signed(128'(cy)))
         + 128'($signed(128'(cz)) * $signed(128'(cz)));
      quo = 64'((c2 << 16) / 128'(len2));
      r.region = REGION_INTERIOR;
      r.distance = 25'(floor_root(quo));
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  function automatic logic signed [15:0] rnd_crd(int mode);
    case (mode)
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // input handshake as seen at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // driver: changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_taken) begin
        dist_q.insert(dist_q.size(), seg_distance(query_q.pop_front()));
      end
      if (query_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 30)) begin
        in_ch.valid <= 1'b1;
        {in_ch.point_x, in_ch.point_y, in_ch.point_z,
         in_ch.start_x, in_ch.start_y, in_ch.start_z,
         in_ch.end_x, in_ch.end_y, in_ch.end_z} <= query_q[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ready stall on the result side
  always @(negedge clk) begin
    out_ch.ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 30);
  end

  // monitor: samples on the rising edge
  always @(posedge clk) begin
    dist_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.distance = out_ch.distance;
      got.region = psd3_region_t'(out_ch.region);
      if (dist_q.size() == 0) begin
        report("unexpected item", got.distance, -1);
      end else begin
        want = dist_q.pop_front();
        if (got.distance !== want.distance) report("distance", got.distance, want.distance);
        if (got.region !== want.region) report("region", got.region, want.region);
      end
    end
  end

  initial begin
    query_t q;
    int m;
    in_ch.valid = 1'b0;
    {in_ch.point_x, in_ch.point_y, in_ch.point_z, in_ch.start_x, in_ch.start_y,
     in_ch.start_z, in_ch.end_x, in_ch.end_y, in_ch.end_z} = '0;
    out_ch.ready = 1'b0;

    // directed: zero-length segment, corners, projection on the end, regions
    add_query('0);
    add_query({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, {3{16'sh8000}}, {3{16'sh8000}}});
    add_query({{3{16'sh8000}}, {3{16'sh7FFF}}, {3{16'sh7FFF}}});
    add_query({{3{16'sh8000}}, {3{16'sh7FFF}}, {3{16'sh8000}}});
    add_query({{3{16'sh7FFF}}, {3{16'sh8000}}, {3{16'sh7FFF}}});
    add_query({16'sh7FFF, 16'sh8000, 16'sh7FFF, {3{16'sh8000}}, {3{16'sh7FFF}}});
    // projection landing exactly on the end
    add_query({16'sd10, 16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
               16'sd10, 16'sd0, 16'sd0});
    add_query({16'sd12, 16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
               16'sd10, 16'sd0, 16'sd0});
    add_query({16'sd4, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
               16'sd10, 16'sd0, 16'sd0});
    add_query({-16'sd4, 16'sd3, 16'sd7, 16'sd0, 16'sd0, 16'sd0,
               16'sd10, 16'sd0, 16'sd0});
    add_query({16'sd0, 16'sh7FFF, 16'sd0, 16'sh8000, 16'sd0, 16'sd0,
               16'sh7FFF, 16'sd0, 16'sd0});
    add_query({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
               16'sh7FFF, 16'sh7FFF, 16'sh8000});

    // random: mixed corner, small and full-range coordinates
    for (int n = 0; n < 950; n++) begin
      m = $urandom_range(0, 3);
      q.px = rnd_crd($urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : m);
      q.py = rnd_crd(m == 2 ? 2 : $urandom_range(1, 3));
      q.pz = rnd_crd(m == 2 ? 2 : $urandom_range(0, 3));
      q.sx = rnd_crd(m == 2 ? 2 : $urandom_range(0, 3));
      q.sy = rnd_crd(m == 2 ? 2 : $urandom_range(0, 3));
      q.sz = rnd_crd(m == 2 ? 2 : $urandom_range(0, 3));
      q.ex = rnd_crd(m == 2 ? 2 : $urandom_range(0, 3));
      q.ey = rnd_crd(m == 2 ? 2 : $urandom_range(0, 3));
      q.ez = rnd_crd(m == 2 ? 2 : $urandom_range(0, 3));
      if ($urandom_range(0, 19) == 0) {q.ex, q.ey, q.ez} = {q.sx, q.sy, q.sz};
      add_query(q);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // one stretch with no idling
    wait (query_q.size() < 600);
    no_idle = 1'b1;
    wait (query_q.size() < 400);
    no_idle = 1'b0;

    wait (query_q.size() == 0 && !in_ch.valid);
    wait (dist_q.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
